### rtl/zrtd_pkg.sv
// Shared types, codes and helper functions for the ZIP Reduce token decoder.
// No dependencies; used by the top level, the checker and the bench.
package zrtd_pkg;

  localparam int unsigned SizesDepth   = 256;
  localparam int unsigned MembersDepth = 16384;

  localparam logic [1:0] KIND_LIT  = 2'd0;
  localparam logic [1:0] KIND_COPY = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [7:0] ESC_MARKER = 8'h90;

  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_DATA  = 3'd1,
    PH_FLAG  = 3'd2,
    PH_BYTE  = 3'd3,
    PH_INDEX = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ES_LIT    = 2'd0,
    ES_MARK   = 2'd1,
    ES_EXTLEN = 2'd2,
    ES_DIST   = 2'd3
  } esc_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  lit;
    logic [12:0] distance;
    logic [8:0]  len;
  } res_t;

  typedef struct packed {
    esc_t       esc;
    logic [3:0] dist_hi;
    logic [8:0] len;
    logic       emit;
    res_t       res;
  } esc_out_t;

  // Smallest width, at least 1, whose range covers the set size.
  function automatic logic [2:0] index_bits(input logic [5:0] size);
    logic [2:0] nb;
    if (size <= 6'd2)       nb = 3'd1;
    else if (size <= 6'd4)  nb = 3'd2;
    else if (size <= 6'd8)  nb = 3'd3;
    else if (size <= 6'd16) nb = 3'd4;
    else if (size <= 6'd32) nb = 3'd5;
    else                    nb = 3'd6;
    return nb;
  endfunction

  // One character through the 0x90 escape machine.
  function automatic esc_out_t esc_step(input esc_t esc, input logic [7:0] c,
                                        input logic [2:0] lvl_raw,
                                        input logic [3:0] dist_hi,
                                        input logic [8:0] len);
    esc_out_t   o;
    logic [2:0] lvl;
    logic [7:0] mask;
    logic [7:0] hi;
    lvl  = (lvl_raw < 3'd1) ? 3'd1 : ((lvl_raw > 3'd4) ? 3'd4 : lvl_raw);
    mask = 8'hFF >> lvl;
    hi   = c >> (4'd8 - {1'b0, lvl});
    o.esc     = esc;
    o.dist_hi = dist_hi;
    o.len     = len;
    o.emit    = 1'b0;
    o.res     = '0;
    unique case (esc)
      ES_LIT: begin
        if (c == ESC_MARKER) begin
          o.esc = ES_MARK;
        end else begin
          o.emit    = 1'b1;
          o.res.lit = c;
        end
      end
      ES_MARK: begin
        if (c == 8'h00) begin
          o.emit    = 1'b1;
          o.res.lit = ESC_MARKER;
          o.esc     = ES_LIT;
        end else begin
          o.dist_hi = hi[3:0];
          o.len     = {1'b0, c & mask};
          o.esc     = ((c & mask) == mask) ? ES_EXTLEN : ES_DIST;
        end
      end
      ES_EXTLEN: begin
        o.len = len + {1'b0, c};
        o.esc = ES_DIST;
      end
      default: begin
        o.emit         = 1'b1;
        o.res.kind     = KIND_COPY;
        o.res.distance = {1'b0, dist_hi, 8'h00} + {5'd0, c} + 13'd1;
        o.res.len      = len + 9'd3;
        o.esc          = ES_LIT;
      end
    endcase
    return o;
  endfunction

endpackage

### rtl/zrtd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module zrtd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/zip_reduce_token_decoder.sv
// ZIP Reduce token decoder: compressed bytes in, literal/copy/error tokens out.
// Depends on zrtd_pkg and zrtd_ram.
//
// Input channel (in_valid/in_ready): one compressed byte per transfer, bits
// consumed LSB first. in_stream_start clears the bit buffer and all decoder
// state before that byte is used, and releases an error halt.
// Output channel (out_valid/out_ready): zero to four tokens per byte; tokens
// past the fourth of one byte are dropped. out_last_of_run marks the final one.
// cfg_wr_en/cfg_wr_data write the reduction level; write only while idle.
// Each byte is accepted, then each header field or symbol field is decoded in
// turn; every decoded character is followed by a follower set size read
// (ST_SZW) and every index symbol by a member read (ST_MEMD), and the run
// closes with the pass that finds too few bits, then the flush. Decoding can
// also wait while the receiver stalls. The follower tables live in two RAMs,
// sizes 256x6 and members 16384x8, whose registered reads set the cost.
// One token is held back until the next one or the end of the run is known,
// so the last-of-run flag is exact. A stalled receiver stalls decoding; no
// token is dropped. Reset clears control state and sets the level to 1.
module zip_reduce_token_decoder
  import zrtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_stream_start,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_token_kind,
  output logic [7:0]  out_literal_value,
  output logic [12:0] out_copy_distance,
  output logic [8:0]  out_copy_length,
  output logic        out_last_of_run
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_SZW,
    ST_MEMD,
    ST_FIN
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  level_r;
  logic [14:0] buf_r, buf_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  phase_t      phase_r, phase_nxt;
  esc_t        esc_r, esc_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [5:0]  size_r, size_nxt;
  logic [3:0]  dhi_r, dhi_nxt;
  logic [8:0]  plen_r, plen_nxt;
  logic        halt_r, halt_nxt;
  res_t        pend_r, pend_nxt;
  logic        pend_v_r, pend_v_nxt;
  res_t        out_r, out_nxt;
  logic        out_v_r, out_v_nxt;
  logic        out_last_r, out_last_nxt;
  logic [2:0]  ntok_r, ntok_nxt;

  logic        sz_we, sz_re;
  logic [7:0]  sz_waddr, sz_raddr;
  logic [5:0]  sz_wdata, sz_rdata;
  logic        mb_we, mb_re;
  logic [13:0] mb_waddr, mb_raddr;
  logic [7:0]  mb_wdata, mb_rdata;

  logic        out_free, can_emit, clr, tok_ok;
  logic [3:0]  cnt_in;
  logic [2:0]  nb;
  logic [5:0]  idx, nfill;
  logic [7:0]  chr;
  esc_out_t    eo;

  zrtd_ram #(.Width(6), .Depth(SizesDepth)) u_sizes (
    .clk, .we(sz_we), .waddr(sz_waddr), .wdata(sz_wdata),
    .re(sz_re), .raddr(sz_raddr), .rdata(sz_rdata)
  );

  zrtd_ram #(.Width(8), .Depth(MembersDepth)) u_members (
    .clk, .we(mb_we), .waddr(mb_waddr), .wdata(mb_wdata),
    .re(mb_re), .raddr(mb_raddr), .rdata(mb_rdata)
  );

  assign out_free = !out_v_r || out_ready;
  assign can_emit = !pend_v_r || out_free;
  assign in_ready = (state_r == ST_IDLE);
  assign tok_ok   = (ntok_r < 3'd4);

  assign out_valid         = out_v_r;
  assign out_token_kind    = out_r.kind;
  assign out_literal_value = out_r.lit;
  assign out_copy_distance = out_r.distance;
  assign out_copy_length   = out_r.len;
  assign out_last_of_run   = out_last_r;

  assign nb  = index_bits(size_r);
  assign idx = 6'(buf_r & ((15'd1 << nb) - 15'd1));
  assign chr = (state_r == ST_MEMD) ? mb_rdata : buf_r[7:0];
  assign eo  = esc_step(esc_r, chr, level_r, dhi_r, plen_r);
  assign clr = in_stream_start;
  assign cnt_in = (cnt_r > 4'd7) ? 4'd7 : cnt_r;
  assign nfill = (fill_r < size_r) ? fill_r + 6'd1 : fill_r;

  always_comb begin
    state_nxt    = state_r;
    buf_nxt      = buf_r;
    cnt_nxt      = cnt_r;
    phase_nxt    = phase_r;
    esc_nxt      = esc_r;
    prev_nxt     = prev_r;
    fill_nxt     = fill_r;
    size_nxt     = size_r;
    dhi_nxt      = dhi_r;
    plen_nxt     = plen_r;
    halt_nxt     = halt_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    out_v_nxt    = out_v_r && !out_ready;
    ntok_nxt     = ntok_r;
    sz_we    = 1'b0;
    sz_waddr = prev_r;
    sz_wdata = buf_r[5:0];
    sz_re    = 1'b0;
    sz_raddr = chr;
    mb_we    = 1'b0;
    mb_waddr = {prev_r, fill_r};
    mb_wdata = buf_r[7:0];
    mb_re    = 1'b0;
    mb_raddr = {prev_r, idx};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ntok_nxt = '0;
          if (clr) begin
            phase_nxt = PH_SIZE;
            esc_nxt   = ES_LIT;
            prev_nxt  = 8'hFF;
            fill_nxt  = '0;
            dhi_nxt   = '0;
            plen_nxt  = '0;
            halt_nxt  = 1'b0;
            buf_nxt   = 15'(in_byte);
            cnt_nxt   = 4'd8;
            state_nxt = ST_DEC;
          end else if (!halt_r) begin
            buf_nxt   = buf_r | 15'({7'd0, in_byte} << cnt_in);
            cnt_nxt   = cnt_in + 4'd8;
            state_nxt = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        if (can_emit) begin
          unique case (phase_r)
            PH_SIZE: begin
              if (cnt_r < 4'd6) begin
                state_nxt = ST_FIN;
              end else begin
                sz_we     = 1'b1;
                size_nxt  = buf_r[5:0];
                buf_nxt   = buf_r >> 6;
                cnt_nxt   = cnt_r - 4'd6;
                fill_nxt  = '0;
                phase_nxt = PH_DATA;
              end
            end
            PH_DATA: begin
              if (fill_r < size_r && cnt_r < 4'd8) begin
                state_nxt = ST_FIN;
              end else begin
                if (fill_r < size_r) begin
                  mb_we   = 1'b1;
                  buf_nxt = buf_r >> 8;
                  cnt_nxt = cnt_r - 4'd8;
                end
                fill_nxt = nfill;
                if (nfill >= size_r) begin
                  fill_nxt = '0;
                  if (prev_r == 8'd0) begin
                    phase_nxt = PH_FLAG;
                  end else begin
                    prev_nxt  = prev_r - 8'd1;
                    phase_nxt = PH_SIZE;
                  end
                end
              end
            end
            PH_FLAG: begin
              if (size_r == 6'd0) begin
                phase_nxt = PH_BYTE;
              end else if (cnt_r < 4'd1) begin
                state_nxt = ST_FIN;
              end else begin
                phase_nxt = buf_r[0] ? PH_BYTE : PH_INDEX;
                buf_nxt   = buf_r >> 1;
                cnt_nxt   = cnt_r - 4'd1;
              end
            end
            PH_BYTE: begin
              if (cnt_r < 4'd8) begin
                state_nxt = ST_FIN;
              end else begin
                buf_nxt   = buf_r >> 8;
                cnt_nxt   = cnt_r - 4'd8;
                prev_nxt  = chr;
                esc_nxt   = eo.esc;
                dhi_nxt   = eo.dist_hi;
                plen_nxt  = eo.len;
                phase_nxt = PH_FLAG;
                sz_re     = 1'b1;
                state_nxt = ST_SZW;
                if (eo.emit && tok_ok) begin
                  if (pend_v_r) begin
                    out_nxt      = pend_r;
                    out_last_nxt = 1'b0;
                    out_v_nxt    = 1'b1;
                  end
                  pend_nxt   = eo.res;
                  pend_v_nxt = 1'b1;
                  ntok_nxt   = ntok_r + 3'd1;
                end
              end
            end
            default: begin
              if (cnt_r < {1'b0, nb}) begin
                state_nxt = ST_FIN;
              end else begin
                buf_nxt = buf_r >> nb;
                cnt_nxt = cnt_r - {1'b0, nb};
                if (idx >= size_r) begin
                  halt_nxt  = 1'b1;
                  state_nxt = ST_FIN;
                  if (tok_ok) begin
                    if (pend_v_r) begin
                      out_nxt      = pend_r;
                      out_last_nxt = 1'b0;
                      out_v_nxt    = 1'b1;
                    end
                    pend_nxt      = '0;
                    pend_nxt.kind = KIND_ERR;
                    pend_v_nxt    = 1'b1;
                    ntok_nxt      = ntok_r + 3'd1;
                  end
                end else begin
                  mb_re     = 1'b1;
                  state_nxt = ST_MEMD;
                end
              end
            end
          endcase
        end
      end
      ST_MEMD: begin
        if (can_emit) begin
          prev_nxt  = chr;
          esc_nxt   = eo.esc;
          dhi_nxt   = eo.dist_hi;
          plen_nxt  = eo.len;
          phase_nxt = PH_FLAG;
          sz_re     = 1'b1;
          state_nxt = ST_SZW;
          if (eo.emit && tok_ok) begin
            if (pend_v_r) begin
              out_nxt      = pend_r;
              out_last_nxt = 1'b0;
              out_v_nxt    = 1'b1;
            end
            pend_nxt   = eo.res;
            pend_v_nxt = 1'b1;
            ntok_nxt   = ntok_r + 3'd1;
          end
        end
      end
      ST_SZW: begin
        size_nxt  = sz_rdata;
        state_nxt = ST_DEC;
      end
      default: begin
        // close the run: the held token is the last one for this byte
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_nxt      = pend_r;
          out_last_nxt = 1'b1;
          out_v_nxt    = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      level_r  <= 3'd1;
      buf_r    <= '0;
      cnt_r    <= '0;
      phase_r  <= PH_SIZE;
      esc_r    <= ES_LIT;
      prev_r   <= 8'hFF;
      fill_r   <= '0;
      size_r   <= '0;
      dhi_r    <= '0;
      plen_r   <= '0;
      halt_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      ntok_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_wr_en) begin
        level_r <= cfg_wr_data;
      end
      buf_r    <= buf_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
      esc_r    <= esc_nxt;
      prev_r   <= prev_nxt;
      fill_r   <= fill_nxt;
      size_r   <= size_nxt;
      dhi_r    <= dhi_nxt;
      plen_r   <= plen_nxt;
      halt_r   <= halt_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      ntok_r   <= ntok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

### rtl/zrtd_checker.sv
// Port-level checker for the ZIP Reduce token decoder, with its bind.
// Depends on zrtd_pkg; attaches to zip_reduce_token_decoder.
module zrtd_checker
  import zrtd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_token_kind,
  input logic [7:0]  out_literal_value,
  input logic [12:0] out_copy_distance,
  input logic [8:0]  out_copy_length
);

  // hold a stalled token
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("token dropped while stalled");

  a_no_valid_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("token valid right after reset");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= KIND_ERR)
    else $error("unknown token kind");

  a_copy_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == KIND_COPY |->
      out_copy_length >= 9'd3 && out_copy_distance != 13'd0 &&
      out_copy_distance <= 13'd4096 && out_literal_value == 8'd0)
    else $error("copy token out of range");

  a_noncopy_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != KIND_COPY |->
      out_copy_length == 9'd0 && out_copy_distance == 13'd0)
    else $error("copy fields set on a non-copy token");

endmodule

bind zip_reduce_token_decoder zrtd_checker u_zrtd_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_token_kind,
  .out_literal_value, .out_copy_distance, .out_copy_length
);

### tb/sv/zip_reduce_token_decoder_tb.sv
// Self-checking bench for the ZIP Reduce token decoder: a header-aware token
// predictor and a FIFO of expected tokens. Depends on zrtd_pkg and the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import zrtd_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  lit;
    logic [12:0] distance;
    logic [8:0]  len;
    logic        last;
  } token_t;

  class token_board;
    logic [2:0]  level;
    logic [14:0] bitbuf;
    int unsigned nbits;
    phase_t      phase;
    esc_t        esc;
    logic [7:0]  prev;
    int unsigned fill;
    logic [5:0]  sizes[256];
    logic [7:0]  members[16384];
    logic [3:0]  dist_hi;
    logic [8:0]  pend_len;
    bit          halted;
    token_t      pending[$];
    token_t      run[$];
    int          errors;

    function void clear_stream();
      bitbuf = '0; nbits = 0; phase = PH_SIZE; esc = ES_LIT; prev = 8'hFF;
      fill = 0; dist_hi = '0; pend_len = '0; halted = 0;
    endfunction

    function void reset_all();
      level = 3'd1; errors = 0;
      foreach (sizes[i]) sizes[i] = '0;
      foreach (members[i]) members[i] = '0;
      clear_stream();
    endfunction

    function logic [7:0] take(int unsigned n);
      logic [7:0] v;
      v = 8'(bitbuf & ((15'd1 << n) - 15'd1));
      bitbuf = bitbuf >> n; nbits -= n;
      return v;
    endfunction

    function void push_token(logic [1:0] k, logic [7:0] l, logic [12:0] d, logic [8:0] n);
      token_t t;
      if (run.size() >= 4) return;
      t.kind = k; t.lit = l; t.distance = d; t.len = n; t.last = 0;
      run.push_back(t);
    endfunction

    function void escape_char(logic [7:0] c);
      int unsigned lv;
      logic [7:0] mask;
      lv = (level < 1) ? 1 : ((level > 4) ? 4 : level);
      mask = 8'hFF >> lv;
      case (esc)
        ES_LIT: if (c == ESC_MARKER) esc = ES_MARK; else push_token(KIND_LIT, c, 0, 0);
        ES_MARK: begin
          if (c == 8'h00) begin
            push_token(KIND_LIT, ESC_MARKER, 0, 0); esc = ES_LIT;
          end else begin
            dist_hi = 4'(c >> (8 - lv));
            pend_len = {1'b0, c & mask};
            esc = ((c & mask) == mask) ? ES_EXTLEN : ES_DIST;
          end
        end
        ES_EXTLEN: begin
          pend_len = pend_len + {1'b0, c}; esc = ES_DIST;
        end
        default: begin
          push_token(KIND_COPY, 0, {1'b0, dist_hi, 8'h00} + 13'(c) + 13'd1, pend_len + 9'd3);
          esc = ES_LIT;
        end
      endcase
    endfunction

    function void decode_bits();
      logic [5:0] sz;
      int unsigned nb, idx;
      forever begin
        sz = sizes[prev];
        case (phase)
          PH_SIZE: begin
            if (nbits < 6) return;
            sizes[prev] = 6'(take(6)); fill = 0; phase = PH_DATA;
          end
          PH_DATA: begin
            if (fill < sz) begin
              if (nbits < 8) return;
              members[{prev, 6'(fill)}] = take(8); fill++;
            end
            if (fill >= sz) begin
              fill = 0;
              if (prev == 0) phase = PH_FLAG;
              else begin prev--; phase = PH_SIZE; end
            end
          end
          PH_FLAG: begin
            if (sz == 0) phase = PH_BYTE;
            else begin
              if (nbits < 1) return;
              phase = take(1) ? PH_BYTE : PH_INDEX;
            end
          end
          PH_BYTE: begin
            if (nbits < 8) return;
            prev = take(8); escape_char(prev); phase = PH_FLAG;
          end
          default: begin
            nb = 1;
            while (nb < 6 && (1 << nb) < sz) nb++;
            if (nbits < nb) return;
            idx = take(nb);
            if (idx >= sz) begin
              push_token(KIND_ERR, 0, 0, 0); halted = 1; return;
            end
            prev = members[{prev, 6'(idx)}]; escape_char(prev); phase = PH_FLAG;
          end
        endcase
      end
    endfunction

    function void note_byte(logic start, logic [7:0] b);
      if (start) clear_stream();
      if (halted) return;
      run.delete();
      if (nbits > 7) nbits = 7;
      bitbuf = bitbuf | (15'(b) << nbits);
      nbits += 8;
      decode_bits();
      if (run.size() > 0) run[run.size()-1].last = 1;
      foreach (run[i]) pending.push_back(run[i]);
    endfunction

    function void check_token(token_t got);
      token_t e;
      if (pending.size() == 0) begin
        $error("token with no expectation: kind %0d", got.kind); errors++; return;
      end
      e = pending.pop_front();
      if (got.kind != e.kind) begin
        $error("token_kind exp %0d got %0d", e.kind, got.kind); errors++; end
      if (got.lit != e.lit) begin
        $error("literal_value exp %0d got %0d", e.lit, got.lit); errors++; end
      if (got.distance != e.distance) begin
        $error("copy_distance exp %0d got %0d", e.distance, got.distance); errors++; end
      if (got.len != e.len) begin
        $error("copy_length exp %0d got %0d", e.len, got.len); errors++; end
      if (got.last != e.last) begin
        $error("last_of_run exp %0d got %0d", e.last, got.last); errors++; end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_wr_en = 0;
  logic [2:0] cfg_wr_data = '0;
  logic in_valid = 0, in_ready, in_stream_start = 0;
  logic [7:0] in_byte = '0;
  logic out_valid, out_ready = 0;
  logic [1:0] out_token_kind;
  logic [7:0] out_literal_value;
  logic [12:0] out_copy_distance;
  logic [8:0] out_copy_length;
  logic out_last_of_run;

  zip_reduce_token_decoder dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_ready, .in_stream_start,
    .in_byte, .out_valid, .out_ready, .out_token_kind, .out_literal_value,
    .out_copy_distance, .out_copy_length, .out_last_of_run
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  token_board board;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0;
  int quiet_cycles = 0;
  logic [7:0] stream_q[$];

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_token({out_token_kind, out_literal_value, out_copy_distance,
                         out_copy_length, out_last_of_run});
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles > 4000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Drop valid only before an idle stretch, so one edge never sees two drives.
  task automatic send_byte(logic start, logic [7:0] b);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1; in_stream_start <= start; in_byte <= b;
    do @(posedge clk); while (!in_ready);
    board.note_byte(start, b);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_level(logic [2:0] lv);
    drain();
    cfg_wr_en <= 1; cfg_wr_data <= lv;
    @(posedge clk);
    cfg_wr_en <= 0;
    board.level = lv;
  endtask

  // Pack bit fields LSB first into the byte queue; partial bits carry over.
  logic [31:0] acc;
  int acc_n;
  task automatic put_bits(logic [7:0] v, int n);
    acc |= 32'(v & ((1 << n) - 1)) << acc_n;
    acc_n += n;
    while (acc_n >= 8) begin
      stream_q.push_back(acc[7:0]); acc >>= 8; acc_n -= 8;
    end
  endtask

  logic [5:0] hsz[256];
  logic [7:0] hmem[256][64];
  logic [7:0] sym_p;

  // Header with mostly empty sets; 'A' follows itself, 0x90 has a 4-bit index.
  task automatic build_header();
    for (int ch = 255; ch >= 0; ch--) begin
      if (ch == 8'h41) hsz[ch] = 6'd1;
      else if (ch == 8'h90) hsz[ch] = 6'd9;
      else if ($urandom_range(99) < 4) hsz[ch] = 6'($urandom_range(1, 8));
      else hsz[ch] = 6'd0;
      put_bits(8'(hsz[ch]), 6);
      for (int k = 0; k < hsz[ch]; k++) begin
        if (ch == 8'h41) hmem[ch][k] = 8'h41;
        else hmem[ch][k] = ($urandom_range(3) == 0) ? ESC_MARKER : 8'($urandom);
        put_bits(hmem[ch][k], 8);
      end
    end
    sym_p = 8'd0;
  endtask

  task automatic build_symbols(int nsym, int corrupt_pct);
    logic [7:0] c;
    int nb, idx;
    for (int s = 0; s < nsym; s++) begin
      if (hsz[sym_p] != 0 && $urandom_range(1) == 1) begin
        put_bits(8'd0, 1);
        nb = 1;
        while (nb < 6 && (1 << nb) < hsz[sym_p]) nb++;
        idx = $urandom_range(hsz[sym_p] - 1);
        if ($urandom_range(99) < corrupt_pct) idx = (1 << nb) - 1;
        put_bits(8'(idx), nb);
        if (idx >= hsz[sym_p]) c = 8'd0;
        else c = hmem[sym_p][idx];
      end else begin
        if (hsz[sym_p] != 0) put_bits(8'd1, 1);
        case ($urandom_range(5))
          0: c = ESC_MARKER;
          1: c = 8'h00;
          2: c = 8'hFF;
          3: c = 8'h41;
          default: c = 8'($urandom);
        endcase
        put_bits(c, 8);
      end
      sym_p = c;
    end
  endtask

  // Literal 'A', then symbols of a flag and a one-bit index: up to four tokens per byte.
  task automatic build_burst(int n);
    if (hsz[sym_p] != 0) put_bits(8'd1, 1);
    put_bits(8'h41, 8);
    repeat (n) put_bits(8'd0, 2);
    sym_p = 8'h41;
  endtask

  task automatic send_queue(logic start);
    foreach (stream_q[i]) send_byte(start && (i == 0), stream_q[i]);
    stream_q.delete();
  endtask

  initial begin
    board = new();
    board.reset_all();
    acc = 0; acc_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    set_level(3'd0);
    build_header();
    send_queue(1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 86; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 86; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      set_level((ph == 3) ? 3'd7 : 3'($urandom_range(7)));
      build_symbols(16, 0);
      if (ph == 1) build_burst(14);
      if (ph == 2) begin
        fork
          begin hold_off = 1; repeat (300) @(posedge clk); hold_off = 0; end
        join_none
      end
      send_queue(1'b0);
      drain(); // sender pauses until all tokens arrive
    end

    // corrupt indexes halt the block until a stream start
    set_level(3'd4);
    build_symbols(8, 100);
    if (acc_n > 0) put_bits(8'd0, 8 - acc_n);
    send_queue(1'b0);
    send_byte(0, 8'hA5);
    send_byte(1, 8'h00);
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
